### design/tsm_pkg.sv
// ----------------------------------------------------------------------------
// Tridiagonal solve/multiply package
// Shared widths, register indexes, datapath operation codes and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam int DATA_W = 32;
  localparam int ROW_W  = 6;
  localparam int CNT_W  = 7;
  localparam int WIDE_W = 66;

  localparam logic CFG_MATRIX_SIZE = 1'b0;
  localparam logic CFG_OPERATION   = 1'b1;

  localparam logic OPER_SOLVE    = 1'b0;
  localparam logic OPER_MULTIPLY = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SG,
    OP_DEN,
    OP_NUM,
    OP_DIVGO,
    OP_RC,
    OP_MULG,
    OP_WRG,
    OP_WRH,
    OP_MULX,
    OP_WRX,
    OP_MMAIN,
    OP_MSUB,
    OP_MSUP,
    OP_MEND
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic             load;
    logic             clr_fault;
    logic             first_row;
    logic             last_row;
    logic             out_load;
    logic [ROW_W-1:0] row_addr;
    logic [ROW_W-1:0] vec_addr;
    logic [ROW_W-1:0] wr_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic fault;
  } dp_status_t;

endpackage

### design/tsm_div.sv
// ----------------------------------------------------------------------------
// Fixed-point divider
// Restoring divider, one quotient bit per cycle, giving (a * 2^FRAC) / b
// truncated toward zero and saturated to 32 bits signed.
// ----------------------------------------------------------------------------
module tsm_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [tsm_pkg::DATA_W-1:0] dividend,
  input  logic signed [tsm_pkg::DATA_W-1:0] divisor,
  output logic                             busy,
  output logic signed [tsm_pkg::DATA_W-1:0] quot,
  output logic                             ovf
);

  localparam int DW = tsm_pkg::DATA_W;
  localparam int NW = DW + FRAC_BITS;
  localparam int CW = $clog2(NW);
  localparam logic [NW-1:0] LIM_POS = NW'({1'b0, {(DW-1){1'b1}}});
  localparam logic [NW-1:0] LIM_NEG = LIM_POS + NW'(1);
  localparam logic [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] den_r;
  logic          neg_r;
  logic          dz_r;
  logic          num_neg_r;

  logic [DW-1:0] mag_a;
  logic [DW-1:0] mag_b;
  logic [DW:0]   rs;
  logic          ge;

  assign mag_a = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
  assign mag_b = divisor[DW-1] ? (~divisor + DW'(1)) : divisor;
  assign rs    = {rem_r[DW-1:0], q_r[NW-1]};
  assign ge    = (rs >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (cnt_r == '0)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r       <= {mag_a, {FRAC_BITS{1'b0}}};
      rem_r     <= '0;
      den_r     <= mag_b;
      neg_r     <= dividend[DW-1] ^ divisor[DW-1];
      dz_r      <= (divisor == '0);
      num_neg_r <= dividend[DW-1];
      cnt_r     <= CW'(NW - 1);
    end else if (busy_r) begin
      rem_r <= ge ? (rs - {1'b0, den_r}) : rs;
      q_r   <= {q_r[NW-2:0], ge};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  // A zero divisor saturates by the sign of the numerator alone.
  always_comb begin
    ovf  = 1'b0;
    quot = q_r[DW-1:0];
    if (dz_r) begin
      ovf  = 1'b1;
      quot = num_neg_r ? Q_MIN : Q_MAX;
    end else if (neg_r) begin
      if (q_r > LIM_NEG) begin
        ovf  = 1'b1;
        quot = Q_MIN;
      end else begin
        quot = ~q_r[DW-1:0] + DW'(1);
      end
    end else if (q_r > LIM_POS) begin
      ovf  = 1'b1;
      quot = Q_MAX;
    end
  end

  assign busy = busy_r;

endmodule

### design/tsm_dpath.sv
// ----------------------------------------------------------------------------
// Tridiagonal solve/multiply datapath
// Row stores, coefficient and result memories, one multiplier, saturating
// adders, the divider and the sticky fault flag.
// ----------------------------------------------------------------------------
module tsm_dpath #(
  parameter int MAX_ROWS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tsm_pkg::dp_cmd_t                  cmd,
  output tsm_pkg::dp_status_t               status,
  input  logic signed [tsm_pkg::DATA_W-1:0] sub_diag,
  input  logic signed [tsm_pkg::DATA_W-1:0] main_diag,
  input  logic signed [tsm_pkg::DATA_W-1:0] super_diag,
  input  logic signed [tsm_pkg::DATA_W-1:0] vector_value,
  output logic signed [tsm_pkg::DATA_W-1:0] out_value
);

  localparam int DW = tsm_pkg::DATA_W;
  localparam int WW = tsm_pkg::WIDE_W;
  localparam int PW = 2 * DW;
  localparam int AW = $clog2(MAX_ROWS);
  localparam logic signed [DW-1:0] ONE_FX = DW'(1 << FRAC_BITS);
  localparam logic signed [WW-1:0] W_MAX  = WW'(64'sh7FFF_FFFF);
  localparam logic signed [WW-1:0] W_MIN  = -W_MAX - WW'(1);

  function automatic logic [DW:0] sat_w(input logic signed [WW-1:0] v);
    logic [DW:0] r;
    if (v > W_MAX) begin
      r = {1'b1, W_MAX[DW-1:0]};
    end else if (v < W_MIN) begin
      r = {1'b1, W_MIN[DW-1:0]};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

  logic [DW-1:0] sub_mem   [MAX_ROWS];
  logic [DW-1:0] main_mem  [MAX_ROWS];
  logic [DW-1:0] super_mem [MAX_ROWS];
  logic [DW-1:0] vec_mem   [MAX_ROWS];
  logic [DW-1:0] g_mem     [MAX_ROWS];
  logic [DW-1:0] h_mem     [MAX_ROWS];
  logic [DW-1:0] res_mem   [MAX_ROWS];

  logic signed [DW-1:0] sub_q, main_q, super_q, vec_q, g_q, h_q, res_q;

  logic signed [PW-1:0] prod_r;
  logic signed [WW-1:0] acc_r;
  logic signed [DW-1:0] den_r, num_r, rc_r, x_r, out_value_r;
  logic                 fault_r;

  logic signed [DW-1:0] mul_a, mul_b;
  logic                 mul_en;
  logic signed [PW-1:0] sh_p;
  logic signed [WW-1:0] sh_w;
  logic [DW:0]          fm_s, den_s, num_s, nsub_s, x_s, acc_s;
  logic signed [DW-1:0] fm_v;
  logic                 fault_set;
  logic                 res_we;
  logic [DW-1:0]        res_d;

  logic                 div_busy, div_ovf;
  logic signed [DW-1:0] div_q;

  tsm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == tsm_pkg::OP_DIVGO),
    .dividend (cmd.first_row ? num_r : ONE_FX),
    .divisor  (den_r),
    .busy     (div_busy),
    .quot     (div_q),
    .ovf      (div_ovf)
  );

  // Products are floored by the arithmetic shift.
  assign sh_p   = prod_r >>> FRAC_BITS;
  assign sh_w   = WW'(sh_p);
  assign fm_s   = sat_w(sh_w);
  assign fm_v   = fm_s[DW-1:0];
  assign den_s  = sat_w(WW'(main_q) + WW'(fm_v));
  assign num_s  = sat_w(WW'(vec_q) - WW'(fm_v));
  assign nsub_s = sat_w(-WW'(sub_q));
  assign x_s    = sat_w(WW'(fm_v) + WW'(h_q));
  assign acc_s  = sat_w(acc_r + sh_w);

  // Ignored coefficients are replaced by zero on both operands.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      tsm_pkg::OP_SG: begin
        mul_a = cmd.last_row ? '0 : super_q;
        mul_b = cmd.last_row ? '0 : g_q;
      end
      tsm_pkg::OP_DEN: begin
        mul_a = cmd.last_row ? '0 : super_q;
        mul_b = cmd.last_row ? '0 : h_q;
      end
      tsm_pkg::OP_MULG: begin
        mul_a = nsub_s[DW-1:0];
        mul_b = rc_r;
      end
      tsm_pkg::OP_WRG: begin
        mul_a = num_r;
        mul_b = rc_r;
      end
      tsm_pkg::OP_MULX: begin
        mul_a = g_q;
        mul_b = x_r;
      end
      tsm_pkg::OP_MMAIN: begin
        mul_a = main_q;
        mul_b = vec_q;
      end
      tsm_pkg::OP_MSUB: begin
        mul_a = cmd.first_row ? '0 : sub_q;
        mul_b = cmd.first_row ? '0 : vec_q;
      end
      tsm_pkg::OP_MSUP: begin
        mul_a = cmd.last_row ? '0 : super_q;
        mul_b = cmd.last_row ? '0 : vec_q;
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    fault_set = 1'b0;
    res_we    = 1'b0;
    res_d     = div_q;
    case (cmd.op)
      tsm_pkg::OP_DEN:  fault_set = fm_s[DW] | den_s[DW];
      tsm_pkg::OP_NUM:  fault_set = fm_s[DW] | num_s[DW];
      tsm_pkg::OP_RC: begin
        fault_set = div_ovf;
        res_we    = cmd.first_row;
      end
      tsm_pkg::OP_MULG: fault_set = nsub_s[DW];
      tsm_pkg::OP_WRG:  fault_set = fm_s[DW];
      tsm_pkg::OP_WRH:  fault_set = fm_s[DW];
      tsm_pkg::OP_WRX: begin
        fault_set = fm_s[DW] | x_s[DW];
        res_we    = 1'b1;
        res_d     = x_s[DW-1:0];
      end
      tsm_pkg::OP_MEND: begin
        fault_set = acc_s[DW];
        res_we    = 1'b1;
        res_d     = acc_s[DW-1:0];
      end
      default: fault_set = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sub_mem[cmd.wr_addr[AW-1:0]]   <= sub_diag;
      main_mem[cmd.wr_addr[AW-1:0]]  <= main_diag;
      super_mem[cmd.wr_addr[AW-1:0]] <= super_diag;
      vec_mem[cmd.wr_addr[AW-1:0]]   <= vector_value;
    end
    sub_q   <= sub_mem[cmd.row_addr[AW-1:0]];
    main_q  <= main_mem[cmd.row_addr[AW-1:0]];
    super_q <= super_mem[cmd.row_addr[AW-1:0]];
    vec_q   <= vec_mem[cmd.vec_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tsm_pkg::OP_WRG) begin
      g_mem[cmd.wr_addr[AW-1:0]] <= fm_v;
    end
    g_q <= g_mem[cmd.row_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tsm_pkg::OP_WRH) begin
      h_mem[cmd.wr_addr[AW-1:0]] <= fm_v;
    end
    h_q <= h_mem[cmd.row_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[cmd.wr_addr[AW-1:0]] <= res_d;
    end
    res_q <= res_mem[cmd.row_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    case (cmd.op)
      tsm_pkg::OP_DEN:  den_r <= den_s[DW-1:0];
      tsm_pkg::OP_NUM:  num_r <= num_s[DW-1:0];
      tsm_pkg::OP_RC: begin
        rc_r <= div_q;
        if (cmd.first_row) begin
          x_r <= div_q;
        end
      end
      tsm_pkg::OP_WRX:  x_r   <= x_s[DW-1:0];
      tsm_pkg::OP_MSUB: acc_r <= sh_w;
      tsm_pkg::OP_MSUP: acc_r <= acc_r + sh_w;
      default: ;
    endcase
    if (cmd.out_load) begin
      out_value_r <= res_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= 1'b0;
    end else if (cmd.clr_fault) begin
      fault_r <= 1'b0;
    end else if (fault_set) begin
      fault_r <= 1'b1;
    end
  end

  assign status.div_busy = div_busy;
  assign status.fault    = fault_r;
  assign out_value       = out_value_r;

endmodule

### design/tsm_ctrl.sv
// ----------------------------------------------------------------------------
// Tridiagonal solve/multiply controller
// Holds the configuration registers and the row count, and sequences the
// load, backward sweep, forward substitution, product and output phases.
// ----------------------------------------------------------------------------
module tsm_ctrl #(
  parameter int MAX_ROWS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_write_en,
  input  logic                        cfg_index,
  input  logic [tsm_pkg::CNT_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tsm_pkg::ROW_W-1:0]   out_row_index,
  output logic                        out_last,
  output tsm_pkg::dp_cmd_t            cmd,
  input  tsm_pkg::dp_status_t         status
);

  localparam int CW = tsm_pkg::CNT_W;
  localparam int RW = tsm_pkg::ROW_W;

  typedef enum logic [4:0] {
    S_IDLE,
    S_B_RD,
    S_B_SG,
    S_B_DEN,
    S_B_NUM,
    S_B_DIV,
    S_B_WAIT,
    S_B_RC,
    S_B_MULG,
    S_B_WRG,
    S_B_WRH,
    S_F_RD,
    S_F_MUL,
    S_F_WR,
    S_M_RD,
    S_M_MAIN,
    S_M_SUB,
    S_M_SUP,
    S_M_END,
    S_E_RD,
    S_E_LOAD,
    S_E_HOLD
  } state_t;

  state_t        state_r;
  logic [CW-1:0] rows_r;
  logic [CW-1:0] i_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] size_r;
  logic          oper_r;
  logic          out_valid_r;
  logic [RW-1:0] out_row_r;
  logic          out_last_r;

  logic [CW-1:0] n_eff;
  logic [CW-1:0] rows_inc;
  logic [CW-1:0] i_dec;
  logic [CW-1:0] i_inc;
  logic          is_first;
  logic          is_last;
  logic          run_go;

  assign n_eff    = (size_r < CW'(2)) ? CW'(2) :
                    ((size_r > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : size_r);
  assign rows_inc = rows_r + CW'(1);
  assign i_dec    = i_r - CW'(1);
  assign i_inc    = i_r + CW'(1);
  assign is_first = (i_r == '0);
  assign is_last  = (i_r == (n_r - CW'(1)));
  assign run_go   = in_valid && (rows_inc >= n_eff);

  always_comb begin
    cmd           = '0;
    cmd.op        = tsm_pkg::OP_NONE;
    cmd.first_row = is_first;
    cmd.last_row  = is_last;
    cmd.row_addr  = i_r[RW-1:0];
    cmd.vec_addr  = i_r[RW-1:0];
    cmd.wr_addr   = i_r[RW-1:0];
    case (state_r)
      S_IDLE: begin
        cmd.wr_addr   = rows_r[RW-1:0];
        cmd.load      = in_valid;
        cmd.clr_fault = run_go;
      end
      S_B_SG:   cmd.op = tsm_pkg::OP_SG;
      S_B_DEN:  cmd.op = tsm_pkg::OP_DEN;
      S_B_NUM:  cmd.op = tsm_pkg::OP_NUM;
      S_B_DIV:  cmd.op = tsm_pkg::OP_DIVGO;
      S_B_RC:   cmd.op = tsm_pkg::OP_RC;
      S_B_MULG: cmd.op = tsm_pkg::OP_MULG;
      S_B_WRG: begin
        cmd.op      = tsm_pkg::OP_WRG;
        cmd.wr_addr = i_dec[RW-1:0];
      end
      S_B_WRH: begin
        cmd.op      = tsm_pkg::OP_WRH;
        cmd.wr_addr = i_dec[RW-1:0];
      end
      S_F_RD:   cmd.row_addr = i_dec[RW-1:0];
      S_F_MUL: begin
        cmd.op       = tsm_pkg::OP_MULX;
        cmd.row_addr = i_dec[RW-1:0];
      end
      S_F_WR: begin
        cmd.op       = tsm_pkg::OP_WRX;
        cmd.row_addr = i_dec[RW-1:0];
      end
      S_M_MAIN: begin
        cmd.op       = tsm_pkg::OP_MMAIN;
        cmd.vec_addr = is_first ? i_r[RW-1:0] : i_dec[RW-1:0];
      end
      S_M_SUB: begin
        cmd.op       = tsm_pkg::OP_MSUB;
        cmd.vec_addr = is_last ? i_r[RW-1:0] : i_inc[RW-1:0];
      end
      S_M_SUP:  cmd.op = tsm_pkg::OP_MSUP;
      S_M_END:  cmd.op = tsm_pkg::OP_MEND;
      S_E_LOAD: cmd.out_load = 1'b1;
      default:  cmd.op = tsm_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= '0;
      i_r         <= '0;
      n_r         <= CW'(2);
      size_r      <= CW'(64);
      oper_r      <= tsm_pkg::OPER_SOLVE;
      out_valid_r <= 1'b0;
      out_row_r   <= '0;
      out_last_r  <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          tsm_pkg::CFG_MATRIX_SIZE: size_r <= cfg_data;
          tsm_pkg::CFG_OPERATION:   oper_r <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (run_go) begin
              rows_r <= '0;
              n_r    <= n_eff;
              if (oper_r == tsm_pkg::OPER_MULTIPLY) begin
                i_r     <= '0;
                state_r <= S_M_RD;
              end else begin
                i_r     <= n_eff - CW'(1);
                state_r <= S_B_RD;
              end
            end else begin
              rows_r <= rows_inc;
            end
          end
        end
        S_B_RD:   state_r <= S_B_SG;
        S_B_SG:   state_r <= S_B_DEN;
        S_B_DEN:  state_r <= S_B_NUM;
        S_B_NUM:  state_r <= S_B_DIV;
        S_B_DIV:  state_r <= S_B_WAIT;
        S_B_WAIT: begin
          if (!status.div_busy) begin
            state_r <= S_B_RC;
          end
        end
        S_B_RC: begin
          // Row zero's division already yields the first solution element.
          if (is_first) begin
            i_r     <= CW'(1);
            state_r <= S_F_RD;
          end else begin
            state_r <= S_B_MULG;
          end
        end
        S_B_MULG: state_r <= S_B_WRG;
        S_B_WRG:  state_r <= S_B_WRH;
        S_B_WRH: begin
          i_r     <= i_dec;
          state_r <= S_B_RD;
        end
        S_F_RD:   state_r <= S_F_MUL;
        S_F_MUL:  state_r <= S_F_WR;
        S_F_WR: begin
          if (is_last) begin
            i_r     <= '0;
            state_r <= S_E_RD;
          end else begin
            i_r     <= i_inc;
            state_r <= S_F_RD;
          end
        end
        S_M_RD:   state_r <= S_M_MAIN;
        S_M_MAIN: state_r <= S_M_SUB;
        S_M_SUB:  state_r <= S_M_SUP;
        S_M_SUP:  state_r <= S_M_END;
        S_M_END: begin
          if (is_last) begin
            i_r     <= '0;
            state_r <= S_E_RD;
          end else begin
            i_r     <= i_inc;
            state_r <= S_M_RD;
          end
        end
        S_E_RD:   state_r <= S_E_LOAD;
        S_E_LOAD: begin
          out_valid_r <= 1'b1;
          out_row_r   <= i_r[RW-1:0];
          out_last_r  <= is_last;
          state_r     <= S_E_HOLD;
        end
        S_E_HOLD: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_inc;
              state_r <= S_E_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_last      = out_last_r;

endmodule

### design/tridiagonal_solve_multiply.sv
// Loading takes one row per cycle; the row that completes the system starts the run.
// Solve: a backward sweep in which each row waits on the bit-serial divider, then
// forward substitution, one row at a time.
// Multiply: each row goes through the single multiplier.
// Results then leave one at a time, each held until the receiver is ready.
// Synchronous reset: size 64, solve, no rows loaded, fault clear; stores keep no reset.
// ----------------------------------------------------------------------------
// Tridiagonal solve/multiply top level
// Loads a tridiagonal system row by row and either solves Ax=b or forms
// r=Ax in signed fixed point, returning one element per transaction.
// ----------------------------------------------------------------------------
module tridiagonal_solve_multiply #(
  parameter int MAX_ROWS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_write_en,
  input  logic                              cfg_index,
  input  logic [tsm_pkg::CNT_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [tsm_pkg::DATA_W-1:0] in_sub_diag,
  input  logic signed [tsm_pkg::DATA_W-1:0] in_main_diag,
  input  logic signed [tsm_pkg::DATA_W-1:0] in_super_diag,
  input  logic signed [tsm_pkg::DATA_W-1:0] in_vector_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tsm_pkg::ROW_W-1:0]         out_row_index,
  output logic signed [tsm_pkg::DATA_W-1:0] out_value,
  output logic                              out_last,
  output logic                              out_fault
);

  tsm_pkg::dp_cmd_t    cmd;
  tsm_pkg::dp_status_t status;

  tsm_ctrl #(.MAX_ROWS(MAX_ROWS)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_index (out_row_index),
    .out_last      (out_last),
    .cmd           (cmd),
    .status        (status)
  );

  tsm_dpath #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .sub_diag     (in_sub_diag),
    .main_diag    (in_main_diag),
    .super_diag   (in_super_diag),
    .vector_value (in_vector_value),
    .out_value    (out_value)
  );

  assign out_fault = status.fault;

endmodule

### verif/tridiagonal_solve_multiply_tb.sv
// ----------------------------------------------------------------------------
// Tridiagonal solve/multiply testbench
// Loads tridiagonal systems row by row, in both solve and multiply mode, over
// a range of matrix sizes. It checks every returned element against an
// in-bench fixed-point model of the Thomas recurrence and the banded product.
// A short table of directed rows comes first, then random systems, with
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tridiagonal_solve_multiply_tb;

  localparam int  DATA_W     = tsm_pkg::DATA_W;
  localparam int  CNT_W      = tsm_pkg::CNT_W;
  localparam int  ROW_W      = tsm_pkg::ROW_W;
  localparam int  ROWS_MAX   = 64;
  localparam int  FRAC       = 16;
  localparam int  RAND_ROWS  = 220;
  localparam int  IDLE_LIMIT = 40000;
  localparam int  SETTLE     = 30;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  logic clk;
  logic rst_n;
  logic cfg_write_en;
  logic cfg_index;
  logic [CNT_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic signed [DATA_W-1:0] in_sub_diag, in_main_diag, in_super_diag, in_vector_value;
  logic out_valid;
  logic out_ready;
  logic [ROW_W-1:0] out_row_index;
  logic signed [DATA_W-1:0] out_value;
  logic out_last;
  logic out_fault;

  tridiagonal_solve_multiply #(.MAX_ROWS(ROWS_MAX), .FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sub_diag(in_sub_diag), .in_main_diag(in_main_diag),
    .in_super_diag(in_super_diag), .in_vector_value(in_vector_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row_index(out_row_index), .out_value(out_value),
    .out_last(out_last), .out_fault(out_fault)
  );

  typedef struct {
    logic [ROW_W-1:0]         row;
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     fault;
  } elem_t;

  typedef struct {
    bit                       set_cfg;
    logic [CNT_W-1:0]         size;
    logic                     oper;
    logic signed [DATA_W-1:0] sub, dia, sup, vec;
    bit                       has_x0;
    logic signed [DATA_W-1:0] x0;
    logic                     x0_fault;
  } stim_row_t;

  elem_t elem_q[$];

  // Shadow copy of the block's registers and row stores.
  logic [CNT_W-1:0]         size_reg;
  logic                     oper_reg;
  logic signed [DATA_W-1:0] sub_m[ROWS_MAX], dia_m[ROWS_MAX], sup_m[ROWS_MAX];
  logic signed [DATA_W-1:0] vec_m[ROWS_MAX], g_m[ROWS_MAX], h_m[ROWS_MAX];
  logic signed [DATA_W-1:0] res_m[ROWS_MAX];
  int unsigned              rows_held;
  bit                       run_fault;

  int errors, checked, solves, products, rows_sent, idle_cyc, recv_mode, big_runs;
  bit gaps_on;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [DATA_W-1:0] sat32(longint v);
    if (v > longint'(Q_MAX)) begin
      run_fault = 1'b1;
      return Q_MAX;
    end
    if (v < longint'(Q_MIN)) begin
      run_fault = 1'b1;
      return Q_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

  // Arithmetic shift of the full product rounds towards minus infinity.
  function automatic longint mul_wide(logic signed [DATA_W-1:0] a,
                                      logic signed [DATA_W-1:0] b);
    return (longint'(a) * longint'(b)) >>> FRAC;
  endfunction

  function automatic logic signed [DATA_W-1:0] qmul(logic signed [DATA_W-1:0] a,
                                                    logic signed [DATA_W-1:0] b);
    return sat32(mul_wide(a, b));
  endfunction

  function automatic logic signed [DATA_W-1:0] qadd(logic signed [DATA_W-1:0] a,
                                                    logic signed [DATA_W-1:0] b);
    return sat32(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [DATA_W-1:0] qdiv(logic signed [DATA_W-1:0] a,
                                                    logic signed [DATA_W-1:0] b);
    if (b == 0) begin
      run_fault = 1'b1;
      return (a < 0) ? Q_MIN : Q_MAX;
    end
    return sat32((longint'(a) * (longint'(1) <<< FRAC)) / longint'(b));
  endfunction

  function automatic void thomas_solve(int n);
    logic signed [DATA_W-1:0] rc, den;
    rc = qdiv(Q_ONE, dia_m[n-1]);
    g_m[n-2] = qmul(sat32(-longint'(sub_m[n-1])), rc);
    h_m[n-2] = qmul(vec_m[n-1], rc);
    for (int i = n - 2; i > 0; i--) begin
      den = qadd(dia_m[i], qmul(sup_m[i], g_m[i]));
      rc = qdiv(Q_ONE, den);
      g_m[i-1] = qmul(sat32(-longint'(sub_m[i])), rc);
      h_m[i-1] = qmul(sat32(longint'(vec_m[i]) - qmul(sup_m[i], h_m[i])), rc);
    end
    res_m[0] = qdiv(sat32(longint'(vec_m[0]) - qmul(sup_m[0], h_m[0])),
                    qadd(dia_m[0], qmul(sup_m[0], g_m[0])));
    for (int i = 1; i < n; i++)
      res_m[i] = qadd(qmul(g_m[i-1], res_m[i-1]), h_m[i-1]);
  endfunction

  function automatic void band_product(int n);
    longint acc;
    for (int i = 0; i < n; i++) begin
      acc = mul_wide(dia_m[i], vec_m[i]);
      if (i > 0) acc += mul_wide(sub_m[i], vec_m[i-1]);
      if (i + 1 < n) acc += mul_wide(sup_m[i], vec_m[i+1]);
      res_m[i] = sat32(acc);
    end
  endfunction

  function automatic int rows_in_use();
    if (size_reg < 2) return 2;
    if (size_reg > ROWS_MAX) return ROWS_MAX;
    return int'(size_reg);
  endfunction

  // Stores one row; when the system is complete, queues its n elements.
  // Returns the number of elements queued.
  function automatic int load_row(logic signed [DATA_W-1:0] s, logic signed [DATA_W-1:0] d,
                                  logic signed [DATA_W-1:0] p, logic signed [DATA_W-1:0] v);
    int n, row;
    elem_t e;
    n = rows_in_use();
    row = rows_held % ROWS_MAX;
    sub_m[row] = s;
    dia_m[row] = d;
    sup_m[row] = p;
    vec_m[row] = v;
    rows_held = row + 1;
    if (rows_held < n) return 0;
    if (oper_reg == tsm_pkg::OPER_MULTIPLY) begin
      band_product(n);
      products++;
    end else begin
      thomas_solve(n);
      solves++;
    end
    for (int i = 0; i < n; i++) begin
      e.row = i[ROW_W-1:0];
      e.value = res_m[i];
      e.last = (i == n - 1);
      e.fault = run_fault;
      elem_q.push_back(e);
    end
    rows_held = 0;
    run_fault = 1'b0;
    return n;
  endfunction

  task automatic write_reg(logic idx, logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    if (idx == tsm_pkg::CFG_MATRIX_SIZE) size_reg = val;
    else oper_reg = val[0];
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  // Lowers valid and waits until every queued element has come back.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (elem_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(logic [CNT_W-1:0] size, logic oper);
    drain();
    write_reg(tsm_pkg::CFG_MATRIX_SIZE, size);
    write_reg(tsm_pkg::CFG_OPERATION, {{(CNT_W-1){1'b0}}, oper});
  endtask

  // Drives one row at the falling edge and holds it until accepted.
  task automatic send_row(logic signed [DATA_W-1:0] s, logic signed [DATA_W-1:0] d,
                          logic signed [DATA_W-1:0] p, logic signed [DATA_W-1:0] v,
                          output int queued);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_sub_diag = s;
    in_main_diag = d;
    in_super_diag = p;
    in_vector_value = v;
    do @(posedge clk); while (!in_ready);
    queued = load_row(s, d, p, v);
    rows_sent++;
  endtask

  function automatic logic signed [DATA_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      2: return 0;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_diag(bit well_posed);
    logic signed [DATA_W-1:0] m;
    if (!well_posed) return rand_coef();
    m = $urandom_range(32'h0002_0000, 32'h0008_0000);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) recv_mode = $urandom_range(0, 2);
    case (recv_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 9) == 0) ? ~out_ready : out_ready;
    endcase
  end

  always @(posedge clk) begin
    elem_t e;
    if (rst_n && out_valid && out_ready) begin
      if (elem_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected element row %0d value %h", out_row_index, out_value);
      end else begin
        e = elem_q.pop_front();
        checked++;
        if (out_row_index !== e.row || out_value !== e.value ||
            out_last !== e.last || out_fault !== e.fault) begin
          errors++;
          if (errors <= 10)
            $display({"ERROR: element mismatch exp row %0d val %h last %b fault %b,",
                      " got row %0d val %h last %b fault %b"},
                     e.row, e.value, e.last, e.fault,
                     out_row_index, out_value, out_last, out_fault);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles, %0d elements outstanding",
               IDLE_LIMIT, elem_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  stim_row_t stim_rows[] = '{
    // Multiply by the identity returns the vector; ignored corners hold extremes.
    '{1, 7'd2, tsm_pkg::OPER_MULTIPLY, Q_MAX, Q_ONE, 0, 32'sh0003_0000, 0, 0, 0},
    '{0, 7'd2, tsm_pkg::OPER_MULTIPLY, 0, Q_ONE, Q_MIN, 32'sh0000_0005,
      1, 32'sh0003_0000, 0},
    // An all-zero system divides by zero.
    '{1, 7'd2, tsm_pkg::OPER_SOLVE, 0, 0, 0, 0, 0, 0, 0},
    '{0, 7'd2, tsm_pkg::OPER_SOLVE, 0, 0, 0, 0, 1, Q_MAX, 1},
    // The most negative value squared saturates.
    '{1, 7'd2, tsm_pkg::OPER_MULTIPLY, 0, Q_MIN, 0, Q_MIN, 0, 0, 0},
    '{0, 7'd2, tsm_pkg::OPER_MULTIPLY, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1, Q_MAX, 1},
    // Identity solve returns b.
    '{1, 7'd3, tsm_pkg::OPER_SOLVE, Q_MIN, Q_ONE, 0, 32'sh0001_2345, 0, 0, 0},
    '{0, 7'd3, tsm_pkg::OPER_SOLVE, 0, Q_ONE, 0, -32'sh0000_7777, 0, 0, 0},
    '{0, 7'd3, tsm_pkg::OPER_SOLVE, 0, Q_ONE, Q_MAX, 32'sh0002_0000,
      1, 32'sh0001_2345, 0},
    // Negative numerator over a zero pivot.
    '{1, 7'd2, tsm_pkg::OPER_SOLVE, 0, 0, 0, -32'sh0001_0000, 0, 0, 0},
    '{0, 7'd2, tsm_pkg::OPER_SOLVE, 0, Q_ONE, 0, 32'sh0001_0000, 0, 0, 0},
    // Size shrunk part way through a load.
    '{1, 7'd8, tsm_pkg::OPER_SOLVE, 32'sh0000_8000, 32'sh0004_0000, 32'sh0000_4000,
      32'sh0001_0000, 0, 0, 0},
    '{0, 7'd8, tsm_pkg::OPER_SOLVE, -32'sh0000_8000, -32'sh0003_0000, 32'sh0001_0000,
      Q_MAX, 0, 0, 0},
    '{0, 7'd8, tsm_pkg::OPER_SOLVE, 32'sh0001_0000, 32'sh0005_0000, -32'sh0000_2000,
      Q_MIN, 0, 0, 0},
    '{1, 7'd2, tsm_pkg::OPER_SOLVE, 32'sh0000_1000, 32'sh0002_0000, 0, 32'sh0000_3000,
      0, 0, 0},
    // Sizes below the minimum clamp to two rows.
    '{1, 7'd0, tsm_pkg::OPER_MULTIPLY, 32'sh1234_5678, -32'sh0002_8000, 32'sh0001_8000,
      32'sh7654_3210, 0, 0, 0},
    '{0, 7'd0, tsm_pkg::OPER_MULTIPLY, -32'sh0001_0000, 32'sh0000_c000, 32'sh5555_aaaa,
      -32'sh0003_0000, 0, 0, 0},
    '{1, 7'd1, tsm_pkg::OPER_SOLVE, 0, 32'sh0003_0000, 32'sh0001_0000, 32'sh0001_0000,
      0, 0, 0},
    '{0, 7'd1, tsm_pkg::OPER_SOLVE, 32'sh0001_0000, 32'sh0004_0000, 0, -32'sh0002_0000,
      0, 0, 0}
  };

  initial begin
    int queued, n, k, rand_rows;
    logic [CNT_W-1:0] size;
    bit well_posed;
    rst_n = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index = tsm_pkg::CFG_MATRIX_SIZE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_sub_diag = '0;
    in_main_diag = '0;
    in_super_diag = '0;
    in_vector_value = '0;
    out_ready = 1'b0;
    recv_mode = 0;
    gaps_on = 1'b0;
    burst_left = 0;
    size_reg = 7'd64;
    oper_reg = tsm_pkg::OPER_SOLVE;
    rows_held = 0;
    run_fault = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].set_cfg) configure(stim_rows[i].size, stim_rows[i].oper);
      send_row(stim_rows[i].sub, stim_rows[i].dia, stim_rows[i].sup, stim_rows[i].vec,
               queued);
      // Where the first element is known outright it replaces the predicted one.
      if (stim_rows[i].has_x0 && queued > 0) begin
        elem_q[elem_q.size() - queued].value = stim_rows[i].x0;
        elem_q[elem_q.size() - queued].fault = stim_rows[i].x0_fault;
      end
    end

    rand_rows = 0;
    big_runs = 0;
    while (rand_rows < RAND_ROWS) begin
      if (rows_held == 0 || $urandom_range(0, 3) == 0) begin
        if (big_runs < 2 && $urandom_range(0, 9) == 0) begin
          size = $urandom_range(0, 1) ? 7'd64 : 7'(($urandom_range(65, 127)));
          big_runs++;
        end else begin
          size = 7'($urandom_range(2, 8));
        end
        configure(size, 1'($urandom_range(0, 1)));
        gaps_on = $urandom_range(0, 3) != 0;
      end
      n = rows_in_use();
      k = (n > rows_held) ? n - rows_held : 1;
      // Now and then a partial load, finished later, at times after a size change.
      if ($urandom_range(0, 7) == 0 && k > 1) k = $urandom_range(1, k - 1);
      well_posed = $urandom_range(0, 4) != 0;
      repeat (k) begin
        send_row(rand_coef(), rand_diag(well_posed), rand_coef(),
                 well_posed ? rand_coef() : $urandom(), queued);
        rand_rows++;
      end
    end

    drain();
    $display("Sent %0d rows: %0d systems solved, %0d multiplied, %0d elements checked.",
             rows_sent, solves, products, checked);
    if (errors == 0 && elem_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d elements never returned", errors, elem_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
design/tsm_pkg.sv
design/tsm_div.sv
design/tsm_dpath.sv
design/tsm_ctrl.sv
design/tridiagonal_solve_multiply.sv
verif/tridiagonal_solve_multiply_tb.sv
